>>> design/jstl_pkg.sv
// Shared types, codes and constants of the JSON scalar token lexer.
package jstl_pkg;

  // Lexer modes, one-hot
  typedef enum logic [7:0] {
    MODE_IDLE    = 8'b0000_0001,
    MODE_TRUE    = 8'b0000_0010,
    MODE_FALSE   = 8'b0000_0100,
    MODE_NULL    = 8'b0000_1000,
    MODE_INT     = 8'b0001_0000,
    MODE_FRAC    = 8'b0010_0000,
    MODE_EXPSIGN = 8'b0100_0000,
    MODE_EXPDIG  = 8'b1000_0000
  } mode_t;

  // Token kinds
  localparam logic [2:0] KIND_TRUE    = 3'd0;
  localparam logic [2:0] KIND_FALSE   = 3'd1;
  localparam logic [2:0] KIND_NULL    = 3'd2;
  localparam logic [2:0] KIND_INTEGER = 3'd3;
  localparam logic [2:0] KIND_NATURAL = 3'd4;
  localparam logic [2:0] KIND_REAL    = 3'd5;
  localparam logic [2:0] KIND_PASS    = 3'd6;
  localparam logic [2:0] KIND_ERROR   = 3'd7;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_FALSE_EXP = 3'd1;
  localparam logic [2:0] ERR_NULL_EXP  = 3'd2;
  localparam logic [2:0] ERR_TRUE_EXP  = 3'd3;
  localparam logic [2:0] ERR_NUM_EXP   = 3'd4;
  localparam logic [2:0] ERR_REAL_EXP  = 3'd5;

  // Whitespace bytes skipped while idle
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  // Result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } lex_in_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [2:0]  error_code;
    logic [63:0] magnitude;
    logic        is_negative;
    logic        range_flag;
    logic [7:0]  passed_byte;
    logic        last_of_run;
  } lex_out_t;

  typedef struct packed {
    mode_t       mode;
    logic [1:0]  lit_pos;
    logic [63:0] digit_value;
    logic        minus_seen;
    logic        part_digit_seen;
    logic        overflow_seen;
  } lex_state_t;

  // Expected letter of a literal after its first letter
  function automatic logic [7:0] lit_char(input mode_t mode, input logic [1:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (mode)
      MODE_TRUE: begin
        case (pos)
          2'd0: c = "r";
          2'd1: c = "u";
          2'd2: c = "e";
          default: c = 8'h00;
        endcase
      end
      MODE_FALSE: begin
        case (pos)
          2'd0: c = "a";
          2'd1: c = "l";
          2'd2: c = "s";
          default: c = "e";
        endcase
      end
      MODE_NULL: begin
        case (pos)
          2'd0: c = "u";
          2'd1: c = "l";
          2'd2: c = "l";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> design/jstl_step.sv
// Combinational lexer step: next state and up to two results for one byte.
module jstl_step (
  input  jstl_pkg::lex_state_t cur,
  input  jstl_pkg::lex_in_t    item,
  output jstl_pkg::lex_state_t nxt,
  output jstl_pkg::lex_out_t   res_a,
  output jstl_pkg::lex_out_t   res_b,
  output logic [1:0]           res_count
);

  logic [7:0]  b;
  logic        is_dig;
  logic [63:0] dig;
  logic [67:0] acc_wide;
  logic        acc_ovf;
  logic        use_idle;
  logic        va;
  logic        vb;
  logic        idle_emit;
  logic        is_space;
  logic        is_e;
  logic [1:0]  lit_last;
  jstl_pkg::lex_out_t int_res;
  jstl_pkg::lex_out_t blank;

  assign b        = item.in_byte;
  assign is_dig   = (b >= "0") && (b <= "9");
  assign dig      = {60'd0, 4'(b - "0")};
  assign is_e     = (b == "e") || (b == "E");
  assign is_space = (b == jstl_pkg::CH_NUL) || (b == jstl_pkg::CH_TAB) ||
                    (b == jstl_pkg::CH_LF) || (b == jstl_pkg::CH_CR) ||
                    (b == jstl_pkg::CH_SP);

  // Multiply by ten and add the digit; any carry out of 64 bits is overflow
  assign acc_wide = {1'b0, cur.digit_value, 3'b000} + {3'b000, cur.digit_value, 1'b0} +
                    {4'd0, dig};
  assign acc_ovf  = cur.overflow_seen || (acc_wide[67:64] != 4'd0);

  // Integer token from the accumulated magnitude
  always_comb begin
    int_res             = '0;
    int_res.magnitude   = cur.digit_value;
    int_res.is_negative = cur.minus_seen;
    if (cur.minus_seen) begin
      int_res.token_kind = jstl_pkg::KIND_INTEGER;
      int_res.range_flag = cur.overflow_seen ||
                           (cur.digit_value[63] && (cur.digit_value[62:0] != 63'd0));
    end else begin
      int_res.token_kind = cur.digit_value[63] ? jstl_pkg::KIND_NATURAL
                                               : jstl_pkg::KIND_INTEGER;
      int_res.range_flag = cur.overflow_seen;
    end
  end

  assign lit_last = (cur.mode == jstl_pkg::MODE_FALSE) ? 2'd3 : 2'd2;

  always_comb begin
    blank     = '0;
    nxt       = cur;
    res_a     = '0;
    res_b     = '0;
    va        = 1'b0;
    vb        = 1'b0;
    use_idle  = 1'b0;
    idle_emit = 1'b0;

    if (item.end_of_input) begin
      // Flush the open token at end of input
      case (cur.mode)
        jstl_pkg::MODE_TRUE: begin
          va = 1'b1;
          res_a.token_kind = jstl_pkg::KIND_ERROR;
          res_a.error_code = jstl_pkg::ERR_TRUE_EXP;
        end
        jstl_pkg::MODE_FALSE: begin
          va = 1'b1;
          res_a.token_kind = jstl_pkg::KIND_ERROR;
          res_a.error_code = jstl_pkg::ERR_FALSE_EXP;
        end
        jstl_pkg::MODE_NULL: begin
          va = 1'b1;
          res_a.token_kind = jstl_pkg::KIND_ERROR;
          res_a.error_code = jstl_pkg::ERR_NULL_EXP;
        end
        jstl_pkg::MODE_INT: begin
          va = 1'b1;
          if (cur.part_digit_seen) begin
            res_a = int_res;
          end else begin
            res_a.token_kind = jstl_pkg::KIND_ERROR;
            res_a.error_code = jstl_pkg::ERR_NUM_EXP;
          end
        end
        jstl_pkg::MODE_FRAC, jstl_pkg::MODE_EXPDIG: begin
          va = 1'b1;
          if (cur.part_digit_seen) begin
            res_a.token_kind = jstl_pkg::KIND_REAL;
          end else begin
            res_a.token_kind = jstl_pkg::KIND_ERROR;
            res_a.error_code = jstl_pkg::ERR_REAL_EXP;
          end
        end
        jstl_pkg::MODE_EXPSIGN: begin
          va = 1'b1;
          res_a.token_kind = jstl_pkg::KIND_ERROR;
          res_a.error_code = jstl_pkg::ERR_REAL_EXP;
        end
        default: va = 1'b0;
      endcase
      nxt.mode    = jstl_pkg::MODE_IDLE;
      nxt.lit_pos = 2'd0;
    end else begin
      case (cur.mode)
        // Match literal letters
        jstl_pkg::MODE_TRUE, jstl_pkg::MODE_FALSE, jstl_pkg::MODE_NULL: begin
          if (b != jstl_pkg::lit_char(cur.mode, cur.lit_pos)) begin
            va = 1'b1;
            res_a.token_kind = jstl_pkg::KIND_ERROR;
            res_a.error_code = (cur.mode == jstl_pkg::MODE_TRUE) ? jstl_pkg::ERR_TRUE_EXP :
                               (cur.mode == jstl_pkg::MODE_FALSE) ? jstl_pkg::ERR_FALSE_EXP :
                                                                    jstl_pkg::ERR_NULL_EXP;
            nxt.mode = jstl_pkg::MODE_IDLE;
          end else if (cur.lit_pos == lit_last) begin
            va = 1'b1;
            res_a.token_kind = (cur.mode == jstl_pkg::MODE_TRUE) ? jstl_pkg::KIND_TRUE :
                               (cur.mode == jstl_pkg::MODE_FALSE) ? jstl_pkg::KIND_FALSE :
                                                                    jstl_pkg::KIND_NULL;
            nxt.mode    = jstl_pkg::MODE_IDLE;
            nxt.lit_pos = 2'd0;
          end else begin
            nxt.lit_pos = cur.lit_pos + 2'd1;
          end
        end
        // Accumulate integer digits, saturating on overflow
        jstl_pkg::MODE_INT: begin
          if (is_dig) begin
            nxt.overflow_seen   = acc_ovf;
            nxt.digit_value     = acc_ovf ? '1 : acc_wide[63:0];
            nxt.part_digit_seen = 1'b1;
          end else if (!cur.part_digit_seen) begin
            va = 1'b1;
            res_a.token_kind = jstl_pkg::KIND_ERROR;
            res_a.error_code = jstl_pkg::ERR_NUM_EXP;
            nxt.mode = jstl_pkg::MODE_IDLE;
          end else if (b == ".") begin
            nxt.mode            = jstl_pkg::MODE_FRAC;
            nxt.part_digit_seen = 1'b0;
          end else if (is_e) begin
            nxt.mode            = jstl_pkg::MODE_EXPSIGN;
            nxt.part_digit_seen = 1'b0;
          end else begin
            va       = 1'b1;
            res_a    = int_res;
            use_idle = 1'b1;
          end
        end
        // Fraction and exponent digits
        jstl_pkg::MODE_FRAC, jstl_pkg::MODE_EXPDIG: begin
          if (is_dig) begin
            nxt.part_digit_seen = 1'b1;
          end else if (!cur.part_digit_seen) begin
            va = 1'b1;
            res_a.token_kind = jstl_pkg::KIND_ERROR;
            res_a.error_code = jstl_pkg::ERR_REAL_EXP;
            nxt.mode = jstl_pkg::MODE_IDLE;
          end else if ((cur.mode == jstl_pkg::MODE_FRAC) && is_e) begin
            nxt.mode            = jstl_pkg::MODE_EXPSIGN;
            nxt.part_digit_seen = 1'b0;
          end else begin
            va               = 1'b1;
            res_a.token_kind = jstl_pkg::KIND_REAL;
            use_idle         = 1'b1;
          end
        end
        // Optional exponent sign
        jstl_pkg::MODE_EXPSIGN: begin
          if (is_dig || (b == "-") || (b == "+")) begin
            nxt.mode            = jstl_pkg::MODE_EXPDIG;
            nxt.part_digit_seen = is_dig;
          end else begin
            va = 1'b1;
            res_a.token_kind = jstl_pkg::KIND_ERROR;
            res_a.error_code = jstl_pkg::ERR_REAL_EXP;
            nxt.mode = jstl_pkg::MODE_IDLE;
          end
        end
        default: use_idle = 1'b1;
      endcase
    end

    // Dispatch on a token's first byte
    if (use_idle) begin
      nxt.lit_pos = 2'd0;
      if (is_space) begin
        nxt.mode = jstl_pkg::MODE_IDLE;
      end else if (b == "t") begin
        nxt.mode = jstl_pkg::MODE_TRUE;
      end else if (b == "f") begin
        nxt.mode = jstl_pkg::MODE_FALSE;
      end else if (b == "n") begin
        nxt.mode = jstl_pkg::MODE_NULL;
      end else if ((b == "-") || is_dig) begin
        nxt.mode            = jstl_pkg::MODE_INT;
        nxt.minus_seen      = (b == "-");
        nxt.part_digit_seen = is_dig;
        nxt.digit_value     = is_dig ? dig : 64'd0;
        nxt.overflow_seen   = 1'b0;
      end else begin
        nxt.mode  = jstl_pkg::MODE_IDLE;
        idle_emit = 1'b1;
      end
    end

    // Pass the byte on into the first free slot
    if (idle_emit) begin
      if (va) begin
        vb                = 1'b1;
        res_b             = blank;
        res_b.token_kind  = jstl_pkg::KIND_PASS;
        res_b.passed_byte = b;
      end else begin
        va                = 1'b1;
        res_a.token_kind  = jstl_pkg::KIND_PASS;
        res_a.passed_byte = b;
      end
    end

    // Mark the final result of this byte
    if (vb) begin
      res_b.last_of_run = 1'b1;
    end else if (va) begin
      res_a.last_of_run = 1'b1;
    end
    res_count = {vb, va & ~vb};
  end

endmodule

>>> design/jstl_fifo.sv
// Result queue: takes up to two results a cycle, hands out one when the reader is ready.
module jstl_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           push_count,
  input  jstl_pkg::lex_out_t   push_a,
  input  jstl_pkg::lex_out_t   push_b,
  output logic                 room_two,
  output logic                 token_valid,
  input  logic                 token_ready,
  output jstl_pkg::lex_out_t   token
);

  jstl_pkg::lex_out_t          entries [jstl_pkg::FIFO_DEPTH];
  logic [jstl_pkg::FIFO_AW-1:0] wr_ptr;
  logic [jstl_pkg::FIFO_AW-1:0] rd_ptr;
  logic [jstl_pkg::FIFO_CW-1:0] count;
  logic [jstl_pkg::FIFO_AW-1:0] wr_ptr_b;
  logic                         pop;

  assign pop         = token_valid && token_ready;
  assign token_valid = (count != '0);
  assign token       = entries[rd_ptr];
  assign room_two    = (count <= jstl_pkg::FIFO_CW'(jstl_pkg::FIFO_DEPTH - 2));
  assign wr_ptr_b    = wr_ptr + 1'b1;

  // Store results in order
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push_a;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr_b] <= push_b;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + jstl_pkg::FIFO_AW'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + jstl_pkg::FIFO_CW'(push_count) - jstl_pkg::FIFO_CW'(pop);
    end
  end

endmodule

>>> design/json_scalar_token_lexer_core.sv
// Top level of the JSON scalar token lexer: input register, lexer step, result queue.
// A byte sits in the input register from the edge that takes its request; once it is processed,
// its results are written to the result queue and offered from there (later under back-pressure).
// Throughput: one byte per cycle while the queue has room; each result is handed out on its own.
// The four-entry result queue must have room for two results before a byte is processed.
// Reset: synchronous, clears the lexer to idle, empties the queue and drops the input register.
module json_scalar_token_lexer_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  jstl_pkg::lex_in_t    item,
  output logic                 token_valid,
  input  logic                 token_ready,
  output jstl_pkg::lex_out_t   token
);

  logic                 stage_valid;
  jstl_pkg::lex_in_t    stage;
  jstl_pkg::lex_state_t lex_state;
  jstl_pkg::lex_state_t lex_state_next;
  jstl_pkg::lex_out_t   res_a;
  jstl_pkg::lex_out_t   res_b;
  logic [1:0]           res_count;
  logic [1:0]           push_count;
  logic                 room_two;
  logic                 fire;

  assign fire       = stage_valid && room_two;
  assign item_ready = !stage_valid || fire;
  assign push_count = fire ? res_count : 2'd0;

  // Hold the accepted request until the queue has room
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage <= item;
    end
  end

  // Advance lexer state when a byte is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state.mode            <= jstl_pkg::MODE_IDLE;
      lex_state.lit_pos         <= 2'd0;
      lex_state.digit_value     <= 64'd0;
      lex_state.minus_seen      <= 1'b0;
      lex_state.part_digit_seen <= 1'b0;
      lex_state.overflow_seen   <= 1'b0;
    end else if (fire) begin
      lex_state <= lex_state_next;
    end
  end

  jstl_step u_step (
    .cur       (lex_state),
    .item      (stage),
    .nxt       (lex_state_next),
    .res_a     (res_a),
    .res_b     (res_b),
    .res_count (res_count)
  );

  jstl_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push_a      (res_a),
    .push_b      (res_b),
    .room_two    (room_two),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token       (token)
  );

endmodule

>>> design/jstl_checker.sv
// Port-level checks of the lexer's result stream, bound to the top level.
module jstl_checker (
  input logic               clk,
  input logic               rst,
  input logic               token_valid,
  input logic               token_ready,
  input jstl_pkg::lex_out_t token
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |=> token_valid && $stable(token))
    else $error("stalled result changed or dropped");

  // Reset empties the result queue
  a_reset: assert property (@(posedge clk) rst |=> !token_valid)
    else $error("result offered right after reset");

  // Only integer kinds carry magnitude, sign or range
  a_int_fields: assert property (@(posedge clk) disable iff (rst)
    token_valid && (token.token_kind != jstl_pkg::KIND_INTEGER) &&
    (token.token_kind != jstl_pkg::KIND_NATURAL)
    |-> (token.magnitude == 64'd0) && !token.is_negative && !token.range_flag)
    else $error("non-integer result carries integer fields");

  // Error code is set exactly on error results
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> ((token.token_kind == jstl_pkg::KIND_ERROR) ==
                     (token.error_code != jstl_pkg::ERR_NONE)))
    else $error("error code does not match kind");

  // A natural never has its sign set or a clear top bit
  a_natural: assert property (@(posedge clk) disable iff (rst)
    token_valid && (token.token_kind == jstl_pkg::KIND_NATURAL)
    |-> !token.is_negative && token.magnitude[63])
    else $error("natural result out of its range");

endmodule

bind json_scalar_token_lexer_core jstl_checker u_jstl_checker (
  .clk         (clk),
  .rst         (rst),
  .token_valid (token_valid),
  .token_ready (token_ready),
  .token       (token)
);
